>>> hw/rtl/iir_filter_direct_form_one_macros.svh
// Assertion macros shared by the filter RTL.
`ifndef IIR_FILTER_DIRECT_FORM_ONE_MACROS_SVH
`define IIR_FILTER_DIRECT_FORM_ONE_MACROS_SVH
// Same-cycle implication, checked on clk and disabled in reset.
`define IIR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on clk and disabled in reset.
`define IIR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> hw/rtl/iir_df1_pkg.sv
// Types, constants and helpers for the direct form I IIR filter.
`timescale 1ns / 1ps
package iir_df1_pkg;
  localparam int MaxOrderDefault    = 2;
  localparam int SampleWidthDefault = 16;
  localparam int CoefWidth          = 24;
  localparam int FracBits           = 20;
  localparam int CfgIndexWidth      = 3;

  localparam logic [CoefWidth-1:0] CoefOne  = 24'h100000;
  localparam logic [CoefWidth-1:0] CoefZero = 24'h000000;

  typedef enum logic [2:0] {
    REG_ORDER = 3'd0,
    REG_B0    = 3'd1,
    REG_B1    = 3'd2,
    REG_B2    = 3'd3,
    REG_A1    = 3'd4,
    REG_A2    = 3'd5,
    REG_RECIP = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_FIN
  } state_t;

  // Term codes in the order they are accumulated; the last one is the scale by 1/a0.
  typedef enum logic [2:0] {
    TERM_B0    = 3'd0,
    TERM_B1    = 3'd1,
    TERM_A1    = 3'd2,
    TERM_B2    = 3'd3,
    TERM_A2    = 3'd4,
    TERM_SCALE = 3'd5
  } term_t;

  // Small modulo by repeated subtraction; v never exceeds four times p.
  function automatic logic [1:0] ring_mod(input logic [2:0] v, input logic [1:0] p);
    logic [2:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (r >= {1'b0, p}) begin
        r = r - {1'b0, p};
      end
    end
    return r[1:0];
  endfunction
endpackage

>>> hw/rtl/iir_filter_direct_form_one.sv
// Direct form I IIR filter with bit-serial multiply-accumulate.
// Each filter word is computed by one shift-and-add multiplier that consumes one coefficient
// bit per cycle: every active term is one load step and 24 bit steps, each term beyond the
// order is skipped in its load step, and the final scale by 1/a0 is one more such term. The
// word is accepted while idle, and its result goes to the output register from the finish
// state, which waits for a full output register to drain. A clear word gives no output and
// leaves the filter idle. The next word is taken while the previous result waits in the
// output register. The user must write configuration through the cfg port only while the
// filter is idle; the block does not enforce it. cfg_ready is always high.
`timescale 1ns / 1ps
`include "iir_filter_direct_form_one_macros.svh"
module iir_filter_direct_form_one
  import iir_df1_pkg::*;
#(
  parameter int MAX_ORDER    = MaxOrderDefault,
  parameter int SAMPLE_WIDTH = SampleWidthDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CfgIndexWidth-1:0]       cfg_index,
  input  logic [CoefWidth-1:0]           cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] filtered,
  output logic                           clipped
);
  localparam int Depth = MAX_ORDER + 1;
  localparam int HW    = (Depth > 2) ? 2 : 1;
  localparam int AccW  = SAMPLE_WIDTH + 31;
  localparam int TW    = AccW - FracBits;
  localparam int CntW  = $clog2(CoefWidth);
  localparam logic [1:0] MaxOrd = 2'(MAX_ORDER);

  // Configuration registers.
  logic [1:0]           order_sel;
  logic [CoefWidth-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2, leading_recip;

  // Histories and ring pointer.
  logic signed [SAMPLE_WIDTH-1:0] xh [Depth];
  logic signed [SAMPLE_WIDTH-1:0] yh [Depth];
  logic [1:0] ring_slot;
  logic [1:0] slot;

  // Serial multiplier datapath.
  state_t state, state_next;
  term_t  term;
  logic signed [AccW-1:0] acc, mcand;
  logic [CoefWidth-1:0]   coef_sr;
  logic [CntW-1:0]        cnt;
  logic                   neg;

  logic [1:0] ord, p, slot_new, h1, h2;
  logic       term_en, in_acc, out_free, mul_last;
  logic signed [AccW-1:0] addend, acc_rnd, res_rnd;
  logic signed [TW-1:0]   t_val, r_val;
  logic signed [SAMPLE_WIDTH-1:0] op_val, r_sat;
  logic [CoefWidth-1:0]   op_coef;
  logic                   op_neg, r_clip;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign mul_last  = (cnt == CntW'(CoefWidth - 1));

  assign ord      = (order_sel > MaxOrd) ? MaxOrd : order_sel;
  assign p        = ord + 2'd1;
  assign slot_new = ring_mod({1'b0, ring_slot} + 3'd1, p);
  assign h1       = ring_mod({1'b0, slot} + {1'b0, p} - 3'd1, p);
  assign h2       = ring_mod({1'b0, slot} + {1'b0, p} - 3'd2, p);

  always_comb begin
    case (term)
      TERM_B0, TERM_SCALE: term_en = 1'b1;
      TERM_B1, TERM_A1:    term_en = (ord >= 2'd1);
      default:             term_en = (ord >= 2'd2);
    endcase
  end

  // Operand selection for the term being loaded.
  always_comb begin
    op_val  = xh[slot[HW-1:0]];
    op_coef = coef_b0;
    op_neg  = 1'b0;
    case (term)
      TERM_B1: begin
        op_val  = xh[h1[HW-1:0]];
        op_coef = coef_b1;
      end
      TERM_A1: begin
        op_val  = yh[h1[HW-1:0]];
        op_coef = coef_a1;
        op_neg  = 1'b1;
      end
      TERM_B2: begin
        op_val  = xh[h2[HW-1:0]];
        op_coef = coef_b2;
      end
      TERM_A2: begin
        op_val  = yh[h2[HW-1:0]];
        op_coef = coef_a2;
        op_neg  = 1'b1;
      end
      TERM_SCALE: op_coef = leading_recip;
      default: ;
    endcase
  end

  // The coefficient's top bit carries negative weight, so its partial product is subtracted.
  always_comb begin
    if (!coef_sr[0]) begin
      addend = '0;
    end else if (neg ^ mul_last) begin
      addend = -mcand;
    end else begin
      addend = mcand;
    end
  end

  assign acc_rnd = acc + AccW'(64'd1 << (FracBits - 1));
  assign t_val   = acc_rnd[AccW-1:FracBits];
  assign res_rnd = acc_rnd;
  assign r_val   = res_rnd[AccW-1:FracBits];

  always_comb begin
    r_clip = (r_val[TW-1:SAMPLE_WIDTH-1] != '0) && (r_val[TW-1:SAMPLE_WIDTH-1] != '1);
    if (!r_clip) begin
      r_sat = r_val[SAMPLE_WIDTH-1:0];
    end else if (r_val[TW-1]) begin
      r_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      r_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && !action) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (term_en) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_last) begin
          state_next = (term == TERM_SCALE) ? ST_FIN : ST_LOAD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      order_sel     <= 2'd0;
      coef_b0       <= CoefOne;
      coef_b1       <= CoefZero;
      coef_b2       <= CoefZero;
      coef_a1       <= CoefZero;
      coef_a2       <= CoefZero;
      leading_recip <= CoefOne;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORDER: order_sel     <= cfg_data[1:0];
        REG_B0:    coef_b0       <= cfg_data;
        REG_B1:    coef_b1       <= cfg_data;
        REG_B2:    coef_b2       <= cfg_data;
        REG_A1:    coef_a1       <= cfg_data;
        REG_A2:    coef_a2       <= cfg_data;
        REG_RECIP: leading_recip <= cfg_data;
        default: ;
      endcase
    end
  end

  // Histories, ring pointer and output word.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Depth; i++) begin
        xh[i] <= '0;
        yh[i] <= '0;
      end
      ring_slot <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        if (action) begin
          for (int i = 0; i < Depth; i++) begin
            xh[i] <= '0;
            yh[i] <= '0;
          end
          ring_slot <= 2'd0;
        end else begin
          xh[slot_new[HW-1:0]] <= sample;
        end
      end
      if (state == ST_FIN && out_free) begin
        yh[slot[HW-1:0]] <= r_sat;
        ring_slot        <= slot;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      filtered <= r_sat;
      clipped  <= r_clip;
    end
  end

  // Serial multiply-accumulate datapath.
  always_ff @(posedge clk) begin
    if (in_acc && !action) begin
      slot <= slot_new;
      term <= TERM_B0;
      acc  <= '0;
    end else if (state == ST_LOAD) begin
      cnt     <= '0;
      coef_sr <= op_coef;
      neg     <= op_neg;
      if (term == TERM_SCALE) begin
        mcand <= AccW'(t_val);
        acc   <= '0;
      end else begin
        mcand <= AccW'(op_val);
      end
      if (!term_en) begin
        term <= term_t'(term + 3'd1);
      end
    end else if (state == ST_MUL) begin
      acc     <= acc + addend;
      mcand   <= mcand <<< 1;
      coef_sr <= coef_sr >> 1;
      cnt     <= cnt + CntW'(1);
      if (mul_last && term != TERM_SCALE) begin
        term <= term_t'(term + 3'd1);
      end
    end
  end

  `IIR_ASSERT_NXT(a_clear_stays_idle, in_acc && action, state == ST_IDLE, "clear left idle")
  `IIR_ASSERT_NXT(a_sample_starts, in_acc && !action, state == ST_LOAD, "sample not started")
  `IIR_ASSERT_NXT(a_fin_holds, state == ST_FIN && !out_free, state == ST_FIN && out_valid,
                  "pending result overwritten")
endmodule

>>> dv/tb_iir_filter_direct_form_one.sv
// Self-checking testbench for the direct form I IIR filter.
`timescale 1ns / 1ps
module tb_iir_filter_direct_form_one;
  import iir_df1_pkg::*;

  localparam int SW = 16;
  localparam int WatchdogLimit = 20000;
  localparam int ClearDrain = 200;

  typedef struct packed {
    logic signed [SW-1:0] filtered;
    logic                 clipped;
  } filter_word_t;

  int errors = 0;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  class filter_scoreboard;
    logic [1:0] order_q;
    logic signed [23:0] coef[7];
    logic signed [SW-1:0] x_hist[3];
    logic signed [SW-1:0] y_hist[3];
    logic [1:0] slot_q;
    filter_word_t pending[$];
    int n_checked;
    int n_clipped;

    function void reset_state();
      order_q = 0;
      foreach (coef[i]) coef[i] = 0;
      coef[REG_B0] = CoefOne;
      coef[REG_RECIP] = CoefOne;
      clear_hist();
      n_checked = 0;
      n_clipped = 0;
    endfunction

    function void clear_hist();
      foreach (x_hist[i]) begin
        x_hist[i] = 0;
        y_hist[i] = 0;
      end
      slot_q = 0;
    endfunction

    function void write_reg(input cfg_reg_t idx, input logic [23:0] data);
      if (idx == REG_ORDER) order_q = data[1:0];
      else coef[idx] = data;
    endfunction

    // Rounds half up and drops twenty fraction bits; >>> floors.
    function longint round_q20(input longint v);
      return (v + (64'sd1 <<< 19)) >>> 20;
    endfunction

    function void note_input(input logic act, input logic signed [SW-1:0] x);
      int ord, p, slot, h;
      longint acc, t, r;
      filter_word_t w;
      if (act) begin
        clear_hist();
        return;
      end
      ord = (order_q > 2) ? 2 : order_q;
      p = ord + 1;
      slot = (slot_q + 1) % p;
      x_hist[slot] = x;
      acc = longint'(coef[REG_B0]) * longint'(x);
      for (int i = 1; i <= ord; i++) begin
        h = (slot + p - i) % p;
        acc += longint'(coef[i == 1 ? REG_B1 : REG_B2]) * longint'(x_hist[h])
             - longint'(coef[i == 1 ? REG_A1 : REG_A2]) * longint'(y_hist[h]);
      end
      t = round_q20(acc);
      r = round_q20(t * longint'(coef[REG_RECIP]));
      w.clipped = 0;
      if (r > 32767) begin r = 32767; w.clipped = 1; end
      if (r < -32768) begin r = -32768; w.clipped = 1; end
      w.filtered = r[SW-1:0];
      y_hist[slot] = w.filtered;
      slot_q = slot[1:0];
      pending.push_back(w);
    endfunction

    task check_result(input logic signed [SW-1:0] f, input logic c);
      filter_word_t w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word filtered=%0d clipped=%0b", f, c));
        return;
      end
      w = pending.pop_front();
      n_checked++;
      if (c) n_clipped++;
      if (f !== w.filtered)
        report($sformatf("filtered %0d, expected %0d", f, w.filtered));
      if (c !== w.clipped)
        report($sformatf("clipped %0b, expected %0b", c, w.clipped));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = 0;
  logic [CoefWidth-1:0] cfg_data = 0;
  logic in_valid = 0, in_ready, action = 0;
  logic signed [SW-1:0] sample = 0;
  logic out_valid, out_ready = 0;
  logic signed [SW-1:0] filtered;
  logic clipped;

  filter_scoreboard sb = new();
  int idle_cycles = 0;
  int stall_mode = 0;
  int n_sent = 0;

  always #10 clk = ~clk;

  iir_filter_direct_form_one dut (.*);

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(action, sample);
      if (out_valid && out_ready) sb.check_result(filtered, clipped);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog expired with %0d words pending", sb.pending.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // The receiver alternates between always ready, random stalls and long stalls.
  always @(negedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 2) != 0);
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic write_cfg(input cfg_reg_t idx, input logic [23:0] data);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (ClearDrain) @(posedge clk);
  endtask

  task automatic send_word(input logic act, input logic signed [SW-1:0] x);
    @(negedge clk);
    in_valid <= 1;
    action <= act;
    sample <= x;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 0;
    repeat ($urandom_range(0, 6)) @(negedge clk);
  endtask

  function automatic logic [23:0] rand_coef(input int kind);
    case (kind)
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom());
      default: return $urandom_range(0, 1) ? 24'($urandom_range(0, 1 << 19))
                                           : -24'($urandom_range(0, 1 << 19));
    endcase
  endfunction

  task automatic random_settings(input int kind);
    write_cfg(REG_ORDER, 24'($urandom_range(0, 3)));
    for (int r = REG_B0; r <= REG_RECIP; r++) write_cfg(cfg_reg_t'(r), rand_coef(kind));
    if (kind == 3) write_cfg(REG_RECIP, 24'($urandom_range(1 << 19, 1 << 21)));
  endtask

  task automatic random_phase(input int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        send_word($urandom_range(0, 19) == 0, 16'($urandom()));
        count--;
      end
      end_burst();
    end
  endtask

  initial begin
    logic signed [SW-1:0] edge_vals[5] = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd1, -16'sd1};
    sb.reset_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: identity at order 0, then gain and feedback at order 2, extremes.
    foreach (edge_vals[i]) send_word(1'b0, edge_vals[i]);
    send_word(1'b1, 16'sh1234);
    end_burst();
    drain();
    write_cfg(REG_ORDER, 24'd2);
    write_cfg(REG_B0, 24'h7FFFFF);
    write_cfg(REG_B1, 24'h800000);
    write_cfg(REG_B2, 24'h080000);
    write_cfg(REG_A1, 24'hF00000);
    write_cfg(REG_A2, 24'h040000);
    write_cfg(REG_RECIP, CoefOne);
    foreach (edge_vals[i]) send_word(1'b0, edge_vals[i]);
    send_word(1'b1, 16'sh0000);
    send_word(1'b0, 16'sh4000);
    end_burst();
    drain();
    // Order three is treated as order two; order change mid-stream keeps history.
    write_cfg(REG_ORDER, 24'd3);
    send_word(1'b0, 16'sh7FFF);
    send_word(1'b0, -16'sh8000);
    end_burst();
    drain();
    write_cfg(REG_ORDER, 24'd1);
    write_cfg(REG_RECIP, CoefZero);
    send_word(1'b0, 16'sh7FFF);
    send_word(1'b0, 16'sh0100);
    end_burst();
    drain();
    write_cfg(REG_RECIP, 24'h800000);
    send_word(1'b0, 16'sh7FFF);
    send_word(1'b0, -16'sh8000);
    end_burst();
    drain();

    // Random phases, each under new settings; mostly stable, moderate coefficients.
    for (int ph = 0; ph < 12; ph++) begin
      random_settings(ph % 4 == 0 ? ph / 4 : 3);
      random_phase(52);
      drain();
    end

    $display("Sent %0d words, checked %0d results, %0d of them clipped.",
             n_sent, sb.n_checked, sb.n_clipped);
    $display("Covered orders 0 to 3, extreme and zero coefficients, clears and stalls.");
    if (errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
